### rtl/brsb_pkg.sv
package brsb_pkg;

  localparam int unsigned LEN_W  = 12;
  localparam int unsigned BYTE_W = 8;
  localparam int unsigned FILL_W = 12;
  localparam int unsigned LEN_RANGE = 2 ** LEN_W;

  typedef enum logic [1:0] {
    OP_APPEND  = 2'd0,
    OP_READ    = 2'd1,
    OP_RELEASE = 2'd2,
    OP_QUERY   = 2'd3
  } opcode_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_OVERFLOW = 2'd1,
    ST_NO_DATA  = 2'd2,
    ST_TOO_LONG = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_READ,
    S_REDUCE,
    S_REL_OUT
  } state_e;

endpackage

### rtl/byte_ring_send_buffer.sv
// channel  direction  handshake                payload
// in       sink       in_valid_i / in_ready_o  opcode, data_byte, first_of_segment, length, offset
// out      source     out_valid_o / out_ready_i status, read_byte, last, fill_level
//
// append and query: the result sits in the output register.
// read: a set-up step, then one byte per cycle from the store's read port when not stalled;
//   the registered read data is the output register, so a stall holds it.
// release: a shift-subtract reduction of length modulo BUF_SIZE (zero steps for
//   BUF_SIZE >= 4096), then the head update and the result in the output register.
// reset clears head, tail, segment flag and control; the byte store is not cleared.
// a new item is taken only in idle and when the output register is free or being taken.
module byte_ring_send_buffer #(
  parameter int unsigned BUF_SIZE = 4096,
  parameter int unsigned MAX_READ = 64
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  brsb_pkg::opcode_e                   opcode_i,
  input  logic [brsb_pkg::BYTE_W-1:0]         data_byte_i,
  input  logic                                first_of_segment_i,
  input  logic [brsb_pkg::LEN_W-1:0]          length_i,
  input  logic [brsb_pkg::LEN_W-1:0]          offset_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output brsb_pkg::status_e                   status_o,
  output logic [brsb_pkg::BYTE_W-1:0]         read_byte_o,
  output logic                                last_o,
  output logic [brsb_pkg::FILL_W-1:0]         fill_level_o
);
  import brsb_pkg::*;

  localparam int unsigned AW  = $clog2(BUF_SIZE);
  localparam int unsigned SW  = ((AW > LEN_W) ? AW : LEN_W) + 1;
  localparam int unsigned CNW = $clog2(MAX_READ + 1);
  localparam int unsigned RED_STEPS =
    (BUF_SIZE >= LEN_RANGE) ? 0 : $clog2((LEN_RANGE + BUF_SIZE - 1) / BUF_SIZE);
  localparam int unsigned STW = (RED_STEPS > 0) ? $clog2(RED_STEPS + 1) : 1;

  localparam logic [SW-1:0] BUF_S  = SW'(BUF_SIZE);
  localparam logic [AW:0]   BUF_A1 = (AW + 1)'(BUF_SIZE);
  localparam logic [AW-1:0] BUF_M1 = AW'(BUF_SIZE - 1);

  logic [BYTE_W-1:0] mem [BUF_SIZE];

  state_e            state_q, state_d;
  logic [AW-1:0]     head_q, head_d;
  logic [AW-1:0]     tail_q, tail_d;
  logic              seg_q, seg_d;
  logic [AW-1:0]     rd_addr_q, rd_addr_d;
  logic [CNW-1:0]    cnt_q, cnt_d;
  logic [LEN_W-1:0]  rem_q, rem_d;
  logic [STW-1:0]    step_q, step_d;
  logic              out_valid_q, out_valid_d;
  status_e           status_q, status_d;
  logic              last_q, last_d;
  logic              out_rd_q, out_rd_d;
  logic [AW-1:0]     fill_q, fill_d;
  logic [BYTE_W-1:0] rdata_q;

  logic              mem_we, mem_re;
  logic [AW-1:0]     fill_now;
  logic              out_free;
  logic              in_fire;
  logic              seg_ok, seg_now, store_ok;
  logic [SW-1:0]     start_sum, rel_sum, sub_val;
  logic [AW-1:0]     start_addr, rel_head;

  assign fill_now = (tail_q >= head_q) ? (tail_q - head_q)
                                       : AW'(BUF_A1 - {1'b0, head_q} + {1'b0, tail_q});
  assign out_free = !out_valid_q || out_ready_i;
  assign in_ready_o = (state_q == S_IDLE) && out_free;
  assign in_fire = in_valid_i && in_ready_o;

  assign seg_ok   = (SW'(fill_now) + SW'(length_i)) < BUF_S;
  assign seg_now  = first_of_segment_i ? seg_ok : seg_q;
  assign store_ok = seg_now && (fill_now < BUF_M1);

  // read start is within one wrap: offset + length <= fill < BUF_SIZE
  assign start_sum  = SW'(head_q) + SW'(offset_i);
  assign start_addr = (start_sum >= BUF_S) ? AW'(start_sum - BUF_S) : AW'(start_sum);

  assign rel_sum  = SW'(head_q) + SW'(rem_q);
  assign rel_head = (rel_sum >= BUF_S) ? AW'(rel_sum - BUF_S) : AW'(rel_sum);
  assign sub_val  = BUF_S << (step_q - STW'(1));

  always_comb begin
    state_d     = state_q;
    head_d      = head_q;
    tail_d      = tail_q;
    seg_d       = seg_q;
    rd_addr_d   = rd_addr_q;
    cnt_d       = cnt_q;
    rem_d       = rem_q;
    step_d      = step_q;
    out_valid_d = out_valid_q && !out_ready_i;
    status_d    = status_q;
    last_d      = last_q;
    out_rd_d    = out_rd_q;
    fill_d      = fill_q;
    mem_we      = 1'b0;
    mem_re      = 1'b0;

    case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          out_rd_d = 1'b0;
          last_d   = 1'b1;
          status_d = ST_OK;
          fill_d   = fill_now;
          case (opcode_i)
            OP_APPEND: begin
              out_valid_d = 1'b1;
              if (first_of_segment_i) begin
                seg_d = seg_ok;
              end
              if (store_ok) begin
                mem_we = 1'b1;
                tail_d = (tail_q == BUF_M1) ? '0 : tail_q + AW'(1);
                fill_d = fill_now + AW'(1);
              end else begin
                status_d = ST_OVERFLOW;
              end
            end
            OP_READ: begin
              if (length_i > LEN_W'(MAX_READ)) begin
                out_valid_d = 1'b1;
                status_d    = ST_TOO_LONG;
              end else if (SW'(fill_now) < (SW'(length_i) + SW'(offset_i))) begin
                out_valid_d = 1'b1;
                status_d    = ST_NO_DATA;
              end else if (length_i == '0) begin
                out_valid_d = 1'b1;
              end else begin
                rd_addr_d = start_addr;
                cnt_d     = CNW'(length_i);
                state_d   = S_READ;
              end
            end
            OP_RELEASE: begin
              rem_d   = length_i;
              step_d  = STW'(RED_STEPS);
              state_d = S_REDUCE;
            end
            OP_QUERY: begin
              out_valid_d = 1'b1;
            end
            default: begin
              out_valid_d = 1'b1;
            end
          endcase
        end
      end

      // the read data register doubles as output register, so a new byte is
      // fetched only when the current one leaves
      S_READ: begin
        if (out_free) begin
          mem_re      = 1'b1;
          out_valid_d = 1'b1;
          out_rd_d    = 1'b1;
          status_d    = ST_OK;
          last_d      = (cnt_q == CNW'(1));
          fill_d      = fill_now;
          rd_addr_d   = (rd_addr_q == BUF_M1) ? '0 : rd_addr_q + AW'(1);
          cnt_d       = cnt_q - CNW'(1);
          if (cnt_q == CNW'(1)) begin
            state_d = S_IDLE;
          end
        end
      end

      // length mod BUF_SIZE, one shifted subtract per cycle
      S_REDUCE: begin
        if (step_q == '0) begin
          head_d  = rel_head;
          state_d = S_REL_OUT;
        end else begin
          if (SW'(rem_q) >= sub_val) begin
            rem_d = LEN_W'(SW'(rem_q) - sub_val);
          end
          step_d = step_q - STW'(1);
        end
      end

      S_REL_OUT: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_rd_d    = 1'b0;
          status_d    = ST_OK;
          last_d      = 1'b1;
          fill_d      = fill_now;
          state_d     = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      head_q      <= '0;
      tail_q      <= '0;
      seg_q       <= 1'b0;
      out_valid_q <= 1'b0;
      cnt_q       <= '0;
      step_q      <= '0;
    end else begin
      state_q     <= state_d;
      head_q      <= head_d;
      tail_q      <= tail_d;
      seg_q       <= seg_d;
      out_valid_q <= out_valid_d;
      cnt_q       <= cnt_d;
      step_q      <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rd_addr_q <= rd_addr_d;
    rem_q     <= rem_d;
    status_q  <= status_d;
    last_q    <= last_d;
    out_rd_q  <= out_rd_d;
    fill_q    <= fill_d;
  end

  // writes and reads never meet on one entry: appends write only in idle and
  // bytes are read only in S_READ
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[tail_q] <= data_byte_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_re) begin
      rdata_q <= mem[rd_addr_q];
    end
  end

  assign out_valid_o  = out_valid_q;
  assign status_o     = status_q;
  assign last_o       = last_q;
  assign read_byte_o  = out_rd_q ? rdata_q : '0;
  assign fill_level_o = FILL_W'(fill_q);

endmodule

### tb/sv/byte_ring_send_buffer_checker.sv
module byte_ring_send_buffer_checker #(
  parameter int unsigned BUF_SIZE = 4096,
  parameter int unsigned MAX_READ = 64
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  input  logic                            in_ready_i,
  input  brsb_pkg::opcode_e               opcode_i,
  input  logic [brsb_pkg::BYTE_W-1:0]     data_byte_i,
  input  logic                            first_of_segment_i,
  input  logic [brsb_pkg::LEN_W-1:0]      length_i,
  input  logic [brsb_pkg::LEN_W-1:0]      offset_i,
  input  logic                            out_valid_i,
  input  logic                            out_ready_i,
  input  brsb_pkg::status_e               status_i,
  input  logic [brsb_pkg::BYTE_W-1:0]     read_byte_i,
  input  logic                            last_i,
  input  logic [brsb_pkg::FILL_W-1:0]     fill_level_i,
  output int unsigned                     head_o,
  output int unsigned                     tail_o,
  output logic [BUF_SIZE-1:0]             written_o,
  output int                              pending_o,
  output int                              errors_o
);
  import brsb_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    status_e             status;
    logic [BYTE_W-1:0]   read_byte;
    logic                last;
    logic [FILL_W-1:0]   fill;
  } ring_result_t;

  ring_result_t      expected_beats[$];
  logic [BYTE_W-1:0] ring_mem [BUF_SIZE];
  logic              seg_ok;
  int                result_count;

  function automatic int unsigned ring_fill();
    return (tail_o + BUF_SIZE - head_o) % BUF_SIZE;
  endfunction

  task automatic flag_mismatch(input string what, input int got, input int want);
    $display("ERROR beat %0d: %s got 0x%0h expected 0x%0h", result_count, what, got, want);
    errors_o++;
  endtask

  task automatic queue_beat(input status_e st, input logic [BYTE_W-1:0] b, input logic lst);
    ring_result_t r;
    r.status    = st;
    r.read_byte = b;
    r.last      = lst;
    r.fill      = FILL_W'(ring_fill());
    expected_beats.push_back(r);
  endtask

  task automatic predict_ring_op(input opcode_e op, input logic [BYTE_W-1:0] data,
                                 input logic first, input int unsigned len,
                                 input int unsigned off);
    int unsigned pos;
    case (op)
      OP_APPEND: begin
        // the segment length check happens only on the first byte; later bytes inherit it
        if (first) seg_ok = (ring_fill() + len < BUF_SIZE);
        if (seg_ok && ring_fill() < BUF_SIZE - 1) begin
          ring_mem[tail_o]  = data;
          written_o[tail_o] = 1'b1;
          tail_o = (tail_o + 1) % BUF_SIZE;
          queue_beat(ST_OK, '0, 1'b1);
        end else begin
          queue_beat(ST_OVERFLOW, '0, 1'b1);
        end
      end
      OP_READ: begin
        if (len > MAX_READ) begin
          queue_beat(ST_TOO_LONG, '0, 1'b1);
        end else if (ring_fill() < len + off) begin
          queue_beat(ST_NO_DATA, '0, 1'b1);
        end else if (len == 0) begin
          queue_beat(ST_OK, '0, 1'b1);
        end else begin
          for (int unsigned i = 0; i < len; i++) begin
            pos = (head_o + off + i) % BUF_SIZE;
            queue_beat(ST_OK, ring_mem[pos], i + 1 == len);
          end
        end
      end
      OP_RELEASE: begin
        head_o = (head_o + len) % BUF_SIZE;
        queue_beat(ST_OK, '0, 1'b1);
      end
      default: queue_beat(ST_OK, '0, 1'b1);
    endcase
  endtask

  task automatic check_result();
    ring_result_t want;
    if (expected_beats.size() == 0) begin
      flag_mismatch("result with nothing expected, status", int'(status_i), 0);
    end else begin
      want = expected_beats.pop_front();
      if (status_i !== want.status)
        flag_mismatch("status", int'(status_i), int'(want.status));
      if (read_byte_i !== want.read_byte)
        flag_mismatch("read_byte", int'(read_byte_i), int'(want.read_byte));
      if (last_i !== want.last)
        flag_mismatch("last", int'(last_i), int'(want.last));
      if (fill_level_i !== want.fill)
        flag_mismatch("fill_level", int'(fill_level_i), int'(want.fill));
    end
    result_count++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_o       = 0;
      tail_o       = 0;
      seg_ok       = 1'b0;
      written_o    = '0;
      errors_o     = 0;
      result_count = 0;
      expected_beats.delete();
    end else begin
      // an input beat is queued before the output is checked, so the oldest stays in front
      if (in_valid_i && in_ready_i)
        predict_ring_op(opcode_i, data_byte_i, first_of_segment_i, 32'(length_i),
                        32'(offset_i));
      if (out_valid_i && out_ready_i) check_result();
    end
    pending_o = expected_beats.size();
  end

endmodule

### tb/sv/byte_ring_send_buffer_test.sv
module byte_ring_send_buffer_test;
  import brsb_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned BUF_SIZE    = 4096;
  localparam int unsigned MAX_READ    = 64;
  localparam int          N_ITEMS     = 330;
  localparam int          STALL_LIMIT = 2000;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_ready;
  opcode_e           opcode = OP_QUERY;
  logic [BYTE_W-1:0] data_byte = '0;
  logic              first_seg = 1'b0;
  logic [LEN_W-1:0]  length = '0;
  logic [LEN_W-1:0]  offset = '0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  status_e           status;
  logic [BYTE_W-1:0] read_byte;
  logic              last;
  logic [FILL_W-1:0] fill_level;

  int unsigned       ring_head;
  int unsigned       ring_tail;
  logic [BUF_SIZE-1:0] written;
  int                pending;
  int                errors;

  logic              calm = 1'b0;
  int                items_sent = 0;
  int                idle_cycles = 0;

  always #1 clk = ~clk;

  byte_ring_send_buffer #(
    .BUF_SIZE (BUF_SIZE),
    .MAX_READ (MAX_READ)
  ) u_dut (
    .clk_i              (clk),
    .rst_ni             (rst_n),
    .in_valid_i         (in_valid),
    .in_ready_o         (in_ready),
    .opcode_i           (opcode),
    .data_byte_i        (data_byte),
    .first_of_segment_i (first_seg),
    .length_i           (length),
    .offset_i           (offset),
    .out_valid_o        (out_valid),
    .out_ready_i        (out_ready),
    .status_o           (status),
    .read_byte_o        (read_byte),
    .last_o             (last),
    .fill_level_o       (fill_level)
  );

  byte_ring_send_buffer_checker #(
    .BUF_SIZE (BUF_SIZE),
    .MAX_READ (MAX_READ)
  ) u_checker (
    .clk_i              (clk),
    .rst_ni             (rst_n),
    .in_valid_i         (in_valid),
    .in_ready_i         (in_ready),
    .opcode_i           (opcode),
    .data_byte_i        (data_byte),
    .first_of_segment_i (first_seg),
    .length_i           (length),
    .offset_i           (offset),
    .out_valid_i        (out_valid),
    .out_ready_i        (out_ready),
    .status_i           (status),
    .read_byte_i        (read_byte),
    .last_i             (last),
    .fill_level_i       (fill_level),
    .head_o             (ring_head),
    .tail_o             (ring_tail),
    .written_o          (written),
    .pending_o          (pending),
    .errors_o           (errors)
  );

  always @(negedge clk) begin
    out_ready <= calm || ($urandom_range(99) >= 22);
  end

  function automatic int unsigned ring_fill();
    return (ring_tail + BUF_SIZE - ring_head) % BUF_SIZE;
  endfunction

  // a read that passes the fill check must only touch bytes that were stored
  function automatic bit read_is_safe(input int unsigned len, input int unsigned off);
    int unsigned f;
    f = ring_fill();
    if (len > MAX_READ || f < len + off) return 1'b1;
    for (int unsigned i = 0; i < len; i++)
      if (!written[(ring_head + off + i) % BUF_SIZE]) return 1'b0;
    return 1'b1;
  endfunction

  // called at a falling edge, returns at the falling edge after the beat is taken
  task automatic send_item(input opcode_e op, input logic [BYTE_W-1:0] data, input logic first,
                           input logic [LEN_W-1:0] len, input logic [LEN_W-1:0] off);
    while (!calm && $urandom_range(99) < 22) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid  <= 1'b1;
    opcode    <= op;
    data_byte <= data;
    first_seg <= first;
    length    <= len;
    offset    <= off;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
    items_sent++;
  endtask

  task automatic send_read(input int unsigned len, input int unsigned off);
    if (!read_is_safe(len, off)) len = $urandom_range(4095, MAX_READ + 1);
    send_item(OP_READ, BYTE_W'($urandom), 1'($urandom_range(1)), LEN_W'(len), LEN_W'(off));
  endtask

  task automatic send_append(input logic [BYTE_W-1:0] data, input logic first,
                             input logic [LEN_W-1:0] len);
    send_item(OP_APPEND, data, first, len, LEN_W'($urandom_range(4095)));
  endtask

  task automatic send_simple(input opcode_e op, input logic [LEN_W-1:0] len);
    send_item(op, BYTE_W'($urandom), 1'($urandom_range(1)), len, LEN_W'($urandom_range(4095)));
  endtask

  initial begin
    while (idle_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles = 0;
      else idle_cycles++;
    end
    $display("FAIL byte_ring_send_buffer");
    $finish;
  end

  initial begin
    int          pick;
    int unsigned fill;
    int unsigned seg_len;
    int unsigned n;
    int unsigned len;

    repeat (3) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed: empty buffer corners
    send_simple(OP_QUERY, 0);
    send_read(0, 0);
    send_read(1, 0);
    send_read(MAX_READ + 1, 0);
    send_read(4095, 4095);
    // zero-length segment still stores its byte
    send_append(8'h00, 1'b1, 0);
    send_append(8'hFF, 1'b1, 4);
    send_append(8'hA5, 1'b0, 4095);
    send_append(8'h5A, 1'b0, 0);
    send_append(8'h01, 1'b0, 7);
    // rejected segment stays rejected for its later bytes
    send_append(8'h77, 1'b1, 4095);
    send_append(8'h88, 1'b0, 1);
    // fill + length hitting the buffer size exactly is rejected, one less is taken
    send_append(8'h3C, 1'b1, LEN_W'(BUF_SIZE - 5));
    send_append(8'hC3, 1'b1, LEN_W'(BUF_SIZE - 6));
    send_read(6, 0);
    send_read(MAX_READ, 0);
    send_read(2, 4);
    send_read(1, 4095);
    send_simple(OP_RELEASE, 2);
    send_simple(OP_QUERY, 0);
    // release past tail leaves the buffer full, then wrap head back onto tail
    send_simple(OP_RELEASE, LEN_W'(ring_fill() + 1));
    send_append(8'h99, 1'b1, 0);
    send_simple(OP_RELEASE, 4095);

    while (items_sent < N_ITEMS) begin
      calm = (items_sent >= 130 && items_sent < 190);
      pick = $urandom_range(99);
      fill = ring_fill();
      if (pick < 40) begin
        pick = $urandom_range(19);
        if (pick == 0) seg_len = 0;
        else if (pick == 1) seg_len = $urandom_range(4095);
        else seg_len = $urandom_range(24, 1);
        n = (seg_len == 0) ? 1 : ((seg_len > 24) ? $urandom_range(4, 1) : seg_len);
        // some segments get cut short
        if ($urandom_range(9) == 0) n = $urandom_range(n, 1);
        for (int unsigned k = 0; k < n; k++)
          send_append(BYTE_W'($urandom), k == 0,
                      (k == 0) ? LEN_W'(seg_len) : LEN_W'($urandom_range(4095)));
      end else if (pick < 65) begin
        if (fill == 0) begin
          send_read($urandom_range(1), 0);
        end else begin
          len = $urandom_range((fill < MAX_READ) ? fill : MAX_READ, 1);
          send_read(len, $urandom_range(fill - len));
        end
      end else if (pick < 80) begin
        if (fill > 2000 && $urandom_range(1)) send_simple(OP_RELEASE, LEN_W'(fill));
        else if ($urandom_range(7) == 0) send_simple(OP_RELEASE, LEN_W'($urandom_range(4095)));
        else send_simple(OP_RELEASE, LEN_W'($urandom_range(fill / 2)));
      end else if (pick < 88) begin
        send_simple(OP_QUERY, LEN_W'($urandom_range(4095)));
      end else begin
        pick = $urandom_range(2);
        if (pick == 0) send_append(BYTE_W'($urandom), 1'b0, LEN_W'($urandom_range(4095)));
        else if (pick == 1) send_read($urandom_range(4095, MAX_READ + 1), $urandom_range(4095));
        else send_read($urandom_range(MAX_READ), $urandom_range(4095));
      end
    end
    calm = 1'b0;
    in_valid <= 1'b0;

    do @(negedge clk); while (pending != 0);
    repeat (10) @(negedge clk);
    if (errors == 0) $display("PASS byte_ring_send_buffer");
    else $display("FAIL byte_ring_send_buffer");
    $finish;
  end

endmodule
